FILE: hw/rtl/shortest_route_finder_assert.svh
// ----------------------------------------------------------------------------
// shortest_route_finder_assert.svh
// Assertion macros used by the route finder checker.
// ----------------------------------------------------------------------------
`ifndef SHORTEST_ROUTE_FINDER_ASSERT_SVH
`define SHORTEST_ROUTE_FINDER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SRF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route finder assertion failed");

// Next-cycle implication, disabled during reset.
`define SRF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route finder assertion failed");

`endif

FILE: hw/rtl/srf_pkg.sv
// ----------------------------------------------------------------------------
// srf_pkg
// Shared constants and codes of the shortest route finder.
// ----------------------------------------------------------------------------
`default_nettype none

package srf_pkg;

  // Parameter defaults
  localparam int MAX_NODES_DEF  = 64;
  localparam int MAX_EDGES_DEF  = 256;
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 6;
  localparam int POS_W  = 16;
  localparam int LEN_W  = 24;
  localparam int STAT_W = 3;
  localparam int DIST_W = 32;
  localparam int SQD_W  = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD_NODE = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_EDGE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BAD_EDGE = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_GRAPH = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE = 3'd4;

  // Distance limits: all ones is unreachable, sums saturate one below
  localparam logic [DIST_W-1:0] DIST_INF = 32'hFFFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFE;

endpackage

`default_nettype wire

FILE: hw/rtl/shortest_route_finder.sv
// ----------------------------------------------------------------------------
// shortest_route_finder
// Road graph store with nearest-node snapping and shortest path query.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Node loads, edge
// loads and clears give a single result that shows on the next cycle, and
// busy stays low. A route query on a loaded graph raises busy until its last
// result. It snaps both points, reading each loaded node, taking differences,
// squaring x then y in the shared squarer and comparing; it fills the distance
// table, then runs up to N rounds (N nodes loaded) of a selection scan over the
// nodes plus a scan of the loaded edges, paced by the single read port of the
// distance memory; the path walk stacks the path, and the output reads it back.
// Results arrive with valid high for one cycle each, not always back to back,
// and last marks the final one; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_route_finder #(
  parameter int MAX_NODES  = srf_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES  = srf_pkg::MAX_EDGES_DEF,
  parameter int COORD_BITS = srf_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [srf_pkg::OP_W-1:0]          operation,
  input  wire logic [srf_pkg::IDX_W-1:0]         node_a,
  input  wire logic [srf_pkg::IDX_W-1:0]         node_b,
  input  wire logic signed [srf_pkg::POS_W-1:0]  pos_x,
  input  wire logic signed [srf_pkg::POS_W-1:0]  pos_y,
  input  wire logic signed [srf_pkg::POS_W-1:0]  dest_x,
  input  wire logic signed [srf_pkg::POS_W-1:0]  dest_y,
  input  wire logic [srf_pkg::LEN_W-1:0]         edge_cost,
  output logic                                   valid,
  output logic [srf_pkg::STAT_W-1:0]             status,
  output logic [srf_pkg::IDX_W-1:0]              node_index,
  output logic signed [srf_pkg::POS_W-1:0]       out_x,
  output logic signed [srf_pkg::POS_W-1:0]       out_y,
  output logic                                   last
);

  import srf_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int NW   = $clog2(MAX_NODES);
  localparam int NCW  = $clog2(MAX_NODES + 1);
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW  = $clog2(MAX_EDGES + 1);
  localparam int SW   = 2 * CW;
  localparam int SQW  = 2 * CW + 1;
  localparam int XW   = 48;
  localparam int EW   = 2 * NW + LEN_W;
  localparam int DEW  = DIST_W + NW + 1;

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_SNAP_RD   = 20'h00002,
    S_SNAP_DIFF = 20'h00004,
    S_SNAP_SQX  = 20'h00008,
    S_SNAP_SQY  = 20'h00010,
    S_SNAP_CMP  = 20'h00020,
    S_INIT      = 20'h00040,
    S_SEL_RD    = 20'h00080,
    S_SEL_CHK   = 20'h00100,
    S_SETTLE    = 20'h00200,
    S_EDGE_RD   = 20'h00400,
    S_EDGE_CHK  = 20'h00800,
    S_RELAX     = 20'h01000,
    S_GOAL_RD   = 20'h02000,
    S_GOAL_CHK  = 20'h04000,
    S_WALK_PUSH = 20'h08000,
    S_WALK_CHK  = 20'h10000,
    S_EMIT_RD   = 20'h20000,
    S_EMIT_NODE = 20'h40000,
    S_EMIT_OUT  = 20'h80000
  } state_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
  } node_ent_t;

  typedef struct packed {
    logic [NW-1:0]    a;
    logic [NW-1:0]    b;
    logic [LEN_W-1:0] len;
  } edge_ent_t;

  typedef struct packed {
    logic              settled;
    logic [NW-1:0]     pred;
    logic [DIST_W-1:0] dval;
  } dist_ent_t;

  // control registers
  state_t         state;
  logic [NCW-1:0] nodes_loaded;
  logic [ECW-1:0] edges_loaded;

  // query working registers
  logic [CW-1:0]     qsx, qsy, qdx, qdy;
  logic              snap_goal;
  logic [NCW-1:0]    idx;
  logic [ECW-1:0]    eidx;
  logic [CW-1:0]     dx, dy;
  logic [SW-1:0]     sqx, sqy;
  logic [SQD_W-1:0]  best_d;
  logic [NW-1:0]     best_i;
  logic [NW-1:0]     start_n, goal_n;
  logic [NW-1:0]     cur, curpred;
  logic [DIST_W-1:0] curd;
  logic              found;
  logic [NW-1:0]     nbr;
  logic [LEN_W-1:0]  elen;
  logic [NW-1:0]     walk;
  logic [NCW-1:0]    plen;
  logic [NCW-1:0]    pos;
  logic [NW-1:0]     pnode;

  // memory ports
  logic            node_we;
  logic [NW-1:0]   node_ra;
  node_ent_t       node_wd, node_rd;
  logic            edge_we;
  edge_ent_t       edge_wd, edge_rd;
  logic            dist_we;
  logic [NW-1:0]   dist_wa, dist_ra;
  dist_ent_t       dist_wd, dist_rd;
  logic            stk_we;
  logic [NW-1:0]   stk_ra;
  logic [NW-1:0]   stk_rd;

  // datapath
  logic             accept;
  logic [CW-1:0]    in_px, in_py, in_dx, in_dy, tx, ty;
  logic signed [CW:0] diff_x, diff_y;
  logic [CW-1:0]    mul_in;
  logic [SW-1:0]    mul_out;
  logic [SQW-1:0]   sq_sum;
  logic [SQD_W-1:0] sq_dist;
  logic             snap_take;
  logic [NW-1:0]    snap_pick;
  logic             idx_last;
  logic             edge_last;
  logic             edge_hit;
  logic [NW-1:0]    nb_c;
  logic [DIST_W:0]  cand;
  logic [DIST_W-1:0] cand_sat;
  logic             relax_take;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // keep the low COORD_BITS of the 16-bit coordinates
  assign in_px = CW'(XW'($unsigned(pos_x)));
  assign in_py = CW'(XW'($unsigned(pos_y)));
  assign in_dx = CW'(XW'($unsigned(dest_x)));
  assign in_dy = CW'(XW'($unsigned(dest_y)));

  assign tx = snap_goal ? qdx : qsx;
  assign ty = snap_goal ? qdy : qsy;

  // signed differences against the node being scanned
  assign diff_x = $signed({node_rd.x[CW-1], node_rd.x}) - $signed({tx[CW-1], tx});
  assign diff_y = $signed({node_rd.y[CW-1], node_rd.y}) - $signed({ty[CW-1], ty});

  // shared squarer: x term then y term
  assign mul_in  = (state == S_SNAP_SQX) ? dx : dy;
  assign mul_out = mul_in * mul_in;

  // saturate squared distance to 64 bits
  assign sq_sum  = {1'b0, sqx} + {1'b0, sqy};
  assign sq_dist = ((sq_sum >> SQD_W) != '0) ? {SQD_W{1'b1}} : SQD_W'(sq_sum);

  assign snap_take = (idx == '0) || (sq_dist < best_d);
  assign snap_pick = snap_take ? idx[NW-1:0] : best_i;
  assign idx_last  = ((idx + NCW'(1)) == nodes_loaded);
  assign edge_last = ((eidx + ECW'(1)) == edges_loaded);

  // edge decode against the settled node
  always_comb begin
    edge_hit = 1'b0;
    nb_c     = edge_rd.b;
    if (edge_rd.a == cur) begin
      edge_hit = 1'b1;
      nb_c     = edge_rd.b;
    end else if (edge_rd.b == cur) begin
      edge_hit = 1'b1;
      nb_c     = edge_rd.a;
    end
    if (NCW'(nb_c) >= nodes_loaded) begin
      edge_hit = 1'b0;
    end
  end

  // saturating candidate distance
  assign cand       = {1'b0, curd} + (DIST_W + 1)'(elen);
  assign cand_sat   = (cand > {1'b0, DIST_MAX}) ? DIST_MAX : cand[DIST_W-1:0];
  assign relax_take = (cand_sat < dist_rd.dval);

  // memory write and read addressing
  always_comb begin
    node_we = accept && (operation == OP_LOAD_NODE) && (nodes_loaded < NCW'(MAX_NODES));
    node_wd = '{x: in_px, y: in_py};
    node_ra = (state == S_EMIT_NODE) ? stk_rd : idx[NW-1:0];

    edge_we = accept && (operation == OP_LOAD_EDGE) && (edges_loaded < ECW'(MAX_EDGES))
              && (7'(node_a) < 7'(nodes_loaded)) && (7'(node_b) < 7'(nodes_loaded))
              && (node_a != node_b);
    edge_wd = '{a: node_a[NW-1:0], b: node_b[NW-1:0], len: edge_cost};

    dist_we = 1'b0;
    dist_wa = idx[NW-1:0];
    dist_wd = '{settled: 1'b0, pred: idx[NW-1:0],
                dval: (idx[NW-1:0] == start_n) ? '0 : DIST_INF};
    case (state)
      S_INIT: begin
        dist_we = 1'b1;
      end
      S_SETTLE: begin
        dist_we = found;
        dist_wa = cur;
        dist_wd = '{settled: 1'b1, pred: curpred, dval: curd};
      end
      S_RELAX: begin
        dist_we = relax_take;
        dist_wa = nbr;
        dist_wd = '{settled: dist_rd.settled, pred: cur, dval: cand_sat};
      end
      default: begin
        dist_we = 1'b0;
      end
    endcase

    case (state)
      S_EDGE_CHK:  dist_ra = nb_c;
      S_GOAL_RD:   dist_ra = goal_n;
      S_WALK_PUSH: dist_ra = walk;
      default:     dist_ra = idx[NW-1:0];
    endcase

    stk_we = (state == S_WALK_PUSH);
    stk_ra = NW'(pos - NCW'(1));
  end

  srf_ram #(.WIDTH(2 * CW), .DEPTH(MAX_NODES)) u_node_mem (
    .clk(clk), .we(node_we), .waddr(nodes_loaded[NW-1:0]), .wdata(node_wd),
    .raddr(node_ra), .rdata(node_rd)
  );

  srf_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_mem (
    .clk(clk), .we(edge_we), .waddr(edges_loaded[EAW-1:0]), .wdata(edge_wd),
    .raddr(eidx[EAW-1:0]), .rdata(edge_rd)
  );

  srf_ram #(.WIDTH(DEW), .DEPTH(MAX_NODES)) u_dist_mem (
    .clk(clk), .we(dist_we), .waddr(dist_wa), .wdata(dist_wd),
    .raddr(dist_ra), .rdata(dist_rd)
  );

  srf_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_mem (
    .clk(clk), .we(stk_we), .waddr(plen[NW-1:0]), .wdata(walk),
    .raddr(stk_ra), .rdata(stk_rd)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      nodes_loaded <= '0;
      edges_loaded <= '0;
      valid        <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            // single-result defaults
            node_index <= '0;
            out_x      <= '0;
            out_y      <= '0;
            last       <= 1'b1;
            status     <= ST_OK;
            case (operation)
              OP_LOAD_NODE: begin
                valid <= 1'b1;
                if (node_we) begin
                  node_index   <= IDX_W'(nodes_loaded);
                  nodes_loaded <= nodes_loaded + NCW'(1);
                end else begin
                  status <= ST_FULL;
                end
              end
              OP_LOAD_EDGE: begin
                valid <= 1'b1;
                if (edges_loaded >= ECW'(MAX_EDGES)) begin
                  status <= ST_FULL;
                end else if (!edge_we) begin
                  status <= ST_BAD_EDGE;
                end else begin
                  edges_loaded <= edges_loaded + ECW'(1);
                end
              end
              OP_QUERY: begin
                if (nodes_loaded == '0) begin
                  valid  <= 1'b1;
                  status <= ST_NO_GRAPH;
                end else begin
                  qsx       <= in_px;
                  qsy       <= in_py;
                  qdx       <= in_dx;
                  qdy       <= in_dy;
                  snap_goal <= 1'b0;
                  idx       <= '0;
                  state     <= S_SNAP_RD;
                end
              end
              default: begin
                valid        <= 1'b1;
                nodes_loaded <= '0;
                edges_loaded <= '0;
              end
            endcase
          end
        end
        S_SNAP_RD: begin
          state <= S_SNAP_DIFF;
        end
        S_SNAP_DIFF: begin
          dx    <= diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
          dy    <= diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
          state <= S_SNAP_SQX;
        end
        S_SNAP_SQX: begin
          sqx   <= mul_out;
          state <= S_SNAP_SQY;
        end
        S_SNAP_SQY: begin
          sqy   <= mul_out;
          state <= S_SNAP_CMP;
        end
        S_SNAP_CMP: begin
          // first minimum wins
          if (snap_take) begin
            best_d <= sq_dist;
            best_i <= idx[NW-1:0];
          end
          if (idx_last) begin
            idx <= '0;
            if (!snap_goal) begin
              start_n   <= snap_pick;
              snap_goal <= 1'b1;
              state     <= S_SNAP_RD;
            end else begin
              goal_n <= snap_pick;
              state  <= S_INIT;
            end
          end else begin
            idx   <= idx + NCW'(1);
            state <= S_SNAP_RD;
          end
        end
        S_INIT: begin
          if (idx_last) begin
            idx   <= '0;
            curd  <= DIST_INF;
            found <= 1'b0;
            state <= S_SEL_RD;
          end else begin
            idx <= idx + NCW'(1);
          end
        end
        S_SEL_RD: begin
          state <= S_SEL_CHK;
        end
        S_SEL_CHK: begin
          // least distance, then least index
          if (!dist_rd.settled && (dist_rd.dval < curd)) begin
            curd    <= dist_rd.dval;
            cur     <= idx[NW-1:0];
            curpred <= dist_rd.pred;
            found   <= 1'b1;
          end
          if (idx_last) begin
            state <= S_SETTLE;
          end else begin
            idx   <= idx + NCW'(1);
            state <= S_SEL_RD;
          end
        end
        S_SETTLE: begin
          if (!found || (cur == goal_n)) begin
            state <= S_GOAL_RD;
          end else if (edges_loaded == '0) begin
            idx   <= '0;
            curd  <= DIST_INF;
            found <= 1'b0;
            state <= S_SEL_RD;
          end else begin
            eidx  <= '0;
            state <= S_EDGE_RD;
          end
        end
        S_EDGE_RD: begin
          state <= S_EDGE_CHK;
        end
        S_EDGE_CHK, S_RELAX: begin
          if ((state == S_EDGE_CHK) && edge_hit) begin
            nbr   <= nb_c;
            elen  <= edge_rd.len;
            state <= S_RELAX;
          end else if (edge_last) begin
            // start the next selection round
            idx   <= '0;
            curd  <= DIST_INF;
            found <= 1'b0;
            state <= S_SEL_RD;
          end else begin
            eidx  <= eidx + ECW'(1);
            state <= S_EDGE_RD;
          end
        end
        S_GOAL_RD: begin
          state <= S_GOAL_CHK;
        end
        S_GOAL_CHK: begin
          if (dist_rd.dval == DIST_INF) begin
            valid      <= 1'b1;
            status     <= ST_NO_ROUTE;
            node_index <= '0;
            out_x      <= '0;
            out_y      <= '0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end else begin
            walk  <= goal_n;
            plen  <= '0;
            state <= S_WALK_PUSH;
          end
        end
        S_WALK_PUSH: begin
          plen <= plen + NCW'(1);
          if ((walk == start_n) || ((plen + NCW'(1)) == nodes_loaded)) begin
            pos   <= plen + NCW'(1);
            state <= S_EMIT_RD;
          end else begin
            state <= S_WALK_CHK;
          end
        end
        S_WALK_CHK: begin
          if (NCW'(dist_rd.pred) >= nodes_loaded) begin
            pos   <= plen;
            state <= S_EMIT_RD;
          end else begin
            walk  <= dist_rd.pred;
            state <= S_WALK_PUSH;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_NODE;
        end
        S_EMIT_NODE: begin
          pnode <= stk_rd;
          state <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          valid      <= 1'b1;
          status     <= ST_OK;
          node_index <= IDX_W'(pnode);
          out_x      <= POS_W'($signed(node_rd.x));
          out_y      <= POS_W'($signed(node_rd.y));
          last       <= (pos == NCW'(1));
          if (pos == NCW'(1)) begin
            state <= S_IDLE;
          end else begin
            pos   <= pos - NCW'(1);
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srf_ram.sv
// ----------------------------------------------------------------------------
// srf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module srf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/srf_checker.sv
// ----------------------------------------------------------------------------
// srf_checker
// Port-level checks of the route finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shortest_route_finder_assert.svh"

module srf_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic [srf_pkg::OP_W-1:0]  operation,
  input wire logic                      valid,
  input wire logic [srf_pkg::STAT_W-1:0] status,
  input wire logic                      last
);

  import srf_pkg::*;

  // loads and clears answer on the next cycle with one final result
  `SRF_ASSERT_NXT(a_load_one_cycle, clk, rst, start && !busy && (operation != OP_QUERY), valid && last && !busy)

  // a query either finishes at once or holds busy
  `SRF_ASSERT_NXT(a_query_busy, clk, rst, start && !busy && (operation == OP_QUERY), busy || (valid && last))

  // error statuses always end their transaction
  `SRF_ASSERT_IMP(a_err_is_last, clk, rst, valid && (status != ST_OK), last)

  // more path nodes to come keeps the block busy
  `SRF_ASSERT_IMP(a_path_busy, clk, rst, valid && !last, busy)

endmodule

bind shortest_route_finder srf_checker u_srf_checker (.*);

`default_nettype wire
